// File: design/hmkv_pkg.sv
package hmkv_pkg;

   localparam int MAX_BUCKETS_DEFAULT = 128;
   localparam int WAYS_DEFAULT = 8;
   localparam int KEY_WIDTH = 31;
   localparam int VALUE_WIDTH = 31;
   localparam int CSR_WIDTH = 8;
   localparam logic [CSR_WIDTH-1:0] RESET_BUCKETS = 8'd100;

   // key bits folded into the remainder per cycle, and division steps per key
   localparam int DIV_BITS = 4;
   localparam int DIV_STEPS = (KEY_WIDTH + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_PAD = DIV_STEPS * DIV_BITS;

   localparam logic [1:0] OP_PUT = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   // unused code, answered as a no operation
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam int REQ_WIDTH = 2 + KEY_WIDTH + VALUE_WIDTH;
   localparam int ENTRY_WIDTH = 1 + KEY_WIDTH + VALUE_WIDTH;

   typedef struct packed {
      logic [1:0] op;
      logic [KEY_WIDTH-1:0] key;
      logic [VALUE_WIDTH-1:0] data;
   } req_type;

   typedef struct packed {
      logic valid;
      logic [KEY_WIDTH-1:0] key;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

   typedef struct packed {
      logic status;
      logic hit;
      logic [VALUE_WIDTH-1:0] data_out;
   } rsp_type;

endpackage

// File: design/hmkv_ram.sv
module hmkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic we,
   input  logic [AW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/hmkv_front.sv
module hmkv_front #(
   parameter int MAX_BUCKETS = 128,
   parameter int BKW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  hmkv_pkg::req_type in_req,
   input  logic [hmkv_pkg::CSR_WIDTH-1:0] bucket_count,
   input  logic hold,
   output logic out_valid,
   input  logic out_ready,
   output hmkv_pkg::req_type out_req,
   output logic [BKW-1:0] out_bucket
);
   import hmkv_pkg::*;

   localparam int RW = $clog2(MAX_BUCKETS + 1);
   localparam int SCW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [RW-1:0] div_ff, div_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [DIV_PAD-1:0] sh_ff, sh_in;
   logic [SCW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] eff;
   logic [RW:0] t;

   always_comb begin
      if (bucket_count == '0) begin
         eff = RW'(1);
      end else if (int'(bucket_count) > MAX_BUCKETS) begin
         eff = RW'(MAX_BUCKETS);
      end else begin
         eff = RW'(bucket_count);
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      t = '0;
      case (state_ff)
         F_IDLE: begin
            if (in_valid && !hold) begin
               req_in = in_req;
               div_in = eff;
               rem_in = '0;
               sh_in = DIV_PAD'(in_req.key);
               cnt_in = '0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            // restoring remainder, a few key bits per cycle
            t = {1'b0, rem_ff};
            for (int i = 0; i < DIV_BITS; i++) begin
               t = {t[RW-1:0], sh_ff[DIV_PAD-1-i]};
               if (t >= {1'b0, div_ff}) begin
                  t = t - {1'b0, div_ff};
               end
            end
            rem_in = t[RW-1:0];
            sh_in = sh_ff << DIV_BITS;
            cnt_in = cnt_ff + SCW'(1);
            if (int'(cnt_ff) == DIV_STEPS - 1) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (out_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      sh_ff <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign in_ready = (state_ff == F_IDLE) && !hold;
   assign out_valid = (state_ff == F_PUSH);
   assign out_req = req_ff;
   assign out_bucket = rem_ff[BKW-1:0];

endmodule

// File: design/hmkv_queue.sv
module hmkv_queue #(
   parameter int WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [WIDTH-1:0] slot_in [2];
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in = slot_ff;
      count_in = count_ff;
      if (pop && count_ff != 2'd0) begin
         slot_in[0] = slot_ff[1];
         count_in = count_ff - 2'd1;
      end
      if (push && count_ff != 2'd2) begin
         slot_in[count_in[0]] = push_data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data = slot_ff[0];

endmodule

// File: design/hmkv_back.sv
module hmkv_back #(
   parameter int MAX_BUCKETS = 128,
   parameter int WAYS = 8,
   parameter int BKW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  hmkv_pkg::req_type in_req,
   input  logic [BKW-1:0] in_bucket,
   output logic in_pop,
   output logic clearing,
   output logic rsp_valid,
   input  logic rsp_ready,
   output hmkv_pkg::rsp_type rsp
);
   import hmkv_pkg::*;

   localparam int DEPTH = MAX_BUCKETS * WAYS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCW = $clog2(WAYS + 1);

   typedef enum logic [3:0] {
      B_CLEAR   = 4'b0001,
      B_IDLE    = 4'b0010,
      B_SCAN    = 4'b0100,
      B_RESOLVE = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [BKW-1:0] bucket_ff, bucket_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [WCW-1:0] iss_ff, iss_in;
   logic [WW-1:0] rd_way_ff, rd_way_in;
   logic rd_vld_ff, rd_vld_in;
   logic found_ff, found_in;
   logic [WW-1:0] fway_ff, fway_in;
   logic [VALUE_WIDTH-1:0] fval_ff, fval_in;
   logic free_ff, free_in;
   logic [WW-1:0] free_way_ff, free_way_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic we;
   logic [AW-1:0] waddr, raddr;
   entry_type wentry, rentry;
   logic [ENTRY_WIDTH-1:0] rdata;
   logic slot_free;

   assign rentry = entry_type'(rdata);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   function automatic logic [AW-1:0] slot_addr(input logic [BKW-1:0] b, input int w);
      return AW'(int'(b) * WAYS + w);
   endfunction

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      bucket_in = bucket_ff;
      clr_in = clr_ff;
      iss_in = iss_ff;
      rd_way_in = rd_way_ff;
      rd_vld_in = 1'b0;
      found_in = found_ff;
      fway_in = fway_ff;
      fval_in = fval_ff;
      free_in = free_ff;
      free_way_in = free_way_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      in_pop = 1'b0;
      we = 1'b0;
      waddr = clr_ff;
      wentry = '0;
      raddr = slot_addr(bucket_ff, int'(iss_ff));
      case (state_ff)
         B_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (int'(clr_ff) == DEPTH - 1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (in_valid) begin
               in_pop = 1'b1;
               req_in = in_req;
               bucket_in = in_bucket;
               iss_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
               state_in = B_SCAN;
            end
         end
         B_SCAN: begin
            if (int'(iss_ff) < WAYS) begin
               rd_vld_in = 1'b1;
               rd_way_in = iss_ff[WW-1:0];
               iss_in = iss_ff + WCW'(1);
            end
            // way data comes back in the cycle after its read
            if (rd_vld_ff) begin
               if (rentry.valid && rentry.key == req_ff.key && !found_ff) begin
                  found_in = 1'b1;
                  fway_in = rd_way_ff;
                  fval_in = rentry.value;
               end
               if (!rentry.valid && !free_ff) begin
                  free_in = 1'b1;
                  free_way_in = rd_way_ff;
               end
            end
            if (int'(iss_ff) == WAYS && !rd_vld_ff) begin
               state_in = B_RESOLVE;
            end
         end
         B_RESOLVE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.hit = found_ff;
               case (req_ff.op)
                  OP_PUT: begin
                     we = found_ff || free_ff;
                     waddr = slot_addr(bucket_ff,
                                       found_ff ? int'(fway_ff) : int'(free_way_ff));
                     wentry = '{valid: 1'b1, key: req_ff.key, value: req_ff.data};
                     rsp_in.status = !found_ff && !free_ff;
                  end
                  OP_GET: begin
                     rsp_in.data_out = found_ff ? fval_ff : '0;
                  end
                  OP_REMOVE: begin
                     we = found_ff;
                     waddr = slot_addr(bucket_ff, int'(fway_ff));
                     wentry = '{valid: 1'b0, key: req_ff.key, value: fval_ff};
                  end
                  default: rsp_in.hit = 1'b0;
               endcase
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      bucket_ff <= bucket_in;
      iss_ff <= iss_in;
      rd_way_ff <= rd_way_in;
      found_ff <= found_in;
      fway_ff <= fway_in;
      fval_ff <= fval_in;
      free_ff <= free_in;
      free_way_ff <= free_way_in;
      rsp_ff <= rsp_in;
   end

   hmkv_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(ENTRY_WIDTH'(wentry)),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign clearing = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// File: design/hash_map_key_value_store_unit.sv
// bucketed key-value table with bounded chains
// req channel: one put, get or remove transaction per item; req_tuser carries the
// operation code (0 put, 1 get, 2 remove), req_tdata the key and the put value.
// rsp channel: exactly one transaction per request, in request order, carrying
// status (put refused, bucket full), hit and the value read by a get.
// csr_we/csr_wdata write the bucket count; zero acts as one, values above
// MAX_BUCKETS act as MAX_BUCKETS. write it only while the unit is idle.
// the front computes key mod bucket count, 4 key bits per cycle, then hands
// the request through a two-entry queue to the back, which reads the bucket's
// ways from a single-port-read table one per cycle and writes back in the
// final cycle. front and back overlap, so the front can take and divide the
// next request while the back still works on the last one. after reset the
// back sweeps all MAX_BUCKETS * WAYS table slots (1024 at defaults), clearing
// the table; req_tready stays low until done.
// a stalled rsp channel holds its result; the back then waits and the queue
// and front keep taking requests until the queue fills.
module hash_map_key_value_store_unit #(
   parameter int MAX_BUCKETS = hmkv_pkg::MAX_BUCKETS_DEFAULT,
   parameter int WAYS = hmkv_pkg::WAYS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,  // key[30:0], data_in[61:31], zero fill
   input  logic [1:0] req_tuser,   // req_type[1:0]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,  // status[0], hit[1], data_out[32:2], zero fill
   input  logic csr_we,
   input  logic [hmkv_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import hmkv_pkg::*;

   localparam int BKW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int QW = BKW + REQ_WIDTH;

   logic [CSR_WIDTH-1:0] buckets_ff;
   req_type in_req, f_req, q_req;
   logic [BKW-1:0] f_bucket, q_bucket;
   logic f_valid, q_full, q_valid, q_pop, clearing;
   logic [QW-1:0] q_data;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         buckets_ff <= RESET_BUCKETS;
      end else if (csr_we) begin
         buckets_ff <= csr_wdata;
      end
   end

   assign in_req = '{op: req_tuser, key: req_tdata[30:0], data: req_tdata[61:31]};

   hmkv_front #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .BKW(BKW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_req(in_req),
      .bucket_count(buckets_ff),
      .hold(clearing),
      .out_valid(f_valid),
      .out_ready(!q_full),
      .out_req(f_req),
      .out_bucket(f_bucket)
   );

   hmkv_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(f_valid),
      .push_data({f_bucket, f_req}),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_valid),
      .head_data(q_data)
   );

   assign q_bucket = q_data[QW-1:REQ_WIDTH];
   assign q_req = req_type'(q_data[REQ_WIDTH-1:0]);

   hmkv_back #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .WAYS(WAYS),
      .BKW(BKW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(q_valid),
      .in_req(q_req),
      .in_bucket(q_bucket),
      .in_pop(q_pop),
      .clearing(clearing),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp(rsp)
   );

   assign rsp_tdata = {7'd0, rsp.data_out, rsp.hit, rsp.status};

`ifndef ASSERT_OFF
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready) else $error("request taken during table clear");

   a_refused_put_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[1]) else $error("refused put with hit");

   a_miss_has_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[32:2] == 31'd0)
      else $error("value returned without hit");
`endif

endmodule

// File: tb/hash_map_key_value_store_unit_tb.sv
`timescale 1ns / 100ps

module hash_map_key_value_store_unit_tb;
   import hmkv_pkg::*;

   localparam int NUM_BUCKETS_MAX = MAX_BUCKETS_DEFAULT;
   localparam int NUM_WAYS = WAYS_DEFAULT;
   localparam int SLOT_COUNT = NUM_BUCKETS_MAX * NUM_WAYS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [1:0] op;
      logic [KEY_WIDTH-1:0] key;
      logic [VALUE_WIDTH-1:0] data;
   } table_op_type;

   typedef struct packed {
      logic status;
      logic hit;
      logic [VALUE_WIDTH-1:0] data_out;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   // shadow table used to predict responses
   logic shadow_valid [SLOT_COUNT];
   logic [KEY_WIDTH-1:0] shadow_key [SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] shadow_value [SLOT_COUNT];
   logic [CSR_WIDTH-1:0] shadow_buckets;

   table_op_type pending_ops[$];
   table_rsp_type expected_rsps[$];
   int error_count = 0;
   int cycle_count = 0;
   int rsp_count = 0;
   int full_count = 0;
   int hit_count = 0;
   int hold_off_cycles = 0;
   bit send_gap_enable = 1'b1;
   int send_gap = 0;
   int recv_gap = 0;

   hash_map_key_value_store_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic table_rsp_type table_apply(table_op_type t);
      table_rsp_type r;
      int nb;
      int base;
      int found;
      int free_slot;
      r = '0;
      nb = (shadow_buckets == 0) ? 1 : int'(shadow_buckets);
      if (nb > NUM_BUCKETS_MAX) nb = NUM_BUCKETS_MAX;
      base = int'(t.key % nb) * NUM_WAYS;
      found = -1;
      free_slot = -1;
      if (t.op == OP_PUT || t.op == OP_GET || t.op == OP_REMOVE) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (found < 0 && shadow_valid[base + w] && shadow_key[base + w] == t.key)
               found = base + w;
            if (free_slot < 0 && !shadow_valid[base + w])
               free_slot = base + w;
         end
         r.hit = (found >= 0);
         case (t.op)
            OP_PUT: begin
               if (found >= 0) shadow_value[found] = t.data;
               else if (free_slot < 0) r.status = 1'b1;
               else begin
                  shadow_valid[free_slot] = 1'b1;
                  shadow_key[free_slot] = t.key;
                  shadow_value[free_slot] = t.data;
               end
            end
            OP_GET: if (found >= 0) r.data_out = shadow_value[found];
            default: if (found >= 0) shadow_valid[found] = 1'b0;
         endcase
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (cycle_count >= 0) cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps = {expected_rsps, table_apply(pending_ops.pop_front())};
            send_gap = send_gap_enable ? gap_length() : 0;
         end else if (!req_tvalid && send_gap > 0) begin
            send_gap = send_gap - 1;
         end
         if ((!req_tvalid || req_tready) && send_gap == 0 && pending_ops.size() > 0) begin
            // next transaction is always the head of the queue
            req_tvalid <= 1'b1;
            req_tuser <= pending_ops[0].op;
            req_tdata <= {2'b00, pending_ops[0].data, pending_ops[0].key};
         end else if (req_tvalid && req_tready) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted down on its own
   always @(posedge clock) begin
      if (!reset && hold_off_cycles > 0) begin
         hold_off_cycles--;
      end
   end

   // monitor
   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[0];
            got.hit = rsp_tdata[1];
            got.data_out = rsp_tdata[32:2];
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction %h", got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d actual %0d", want.hit, got.hit);
                  error_count++;
               end
               if (got.data_out !== want.data_out) begin
                  $error("data_out: expected %h actual %h", want.data_out, got.data_out);
                  error_count++;
               end
               if (want.status) full_count++;
               if (want.hit) hit_count++;
            end
            recv_gap = gap_length();
         end
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic queue_op(logic [1:0] op, logic [KEY_WIDTH-1:0] key,
                           logic [VALUE_WIDTH-1:0] data);
      table_op_type t;
      t.op = op;
      t.key = key;
      t.data = data;
      pending_ops = {pending_ops, t};
   endtask

   task automatic drain();
      while (pending_ops.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_buckets(logic [CSR_WIDTH-1:0] n);
      csr_we <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_buckets = n;
   endtask

   // random content: keys from a small pool so that gets and removes hit
   task automatic random_phase(int count, int key_span);
      logic [1:0] op;
      logic [KEY_WIDTH-1:0] k;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: op = OP_NOP;
            1, 2, 3, 4, 5, 6, 7, 8: op = OP_PUT;
            9, 10, 11, 12, 13, 14: op = OP_GET;
            default: op = OP_REMOVE;
         endcase
         if ($urandom_range(0, 9) == 0) k = KEY_WIDTH'($urandom() >> 1);
         else k = KEY_WIDTH'($urandom_range(0, key_span));
         queue_op(op, k, VALUE_WIDTH'($urandom() >> 1));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i] = '0;
         shadow_value[i] = '0;
      end
      shadow_buckets = RESET_BUCKETS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, overwrite, full bucket, misses, unused code
      queue_op(OP_GET, 31'd5, '1);
      queue_op(OP_PUT, '1, '1);
      queue_op(OP_GET, '1, '0);
      queue_op(OP_PUT, 31'd0, 31'd0);
      queue_op(OP_PUT, 31'd0, 31'h2aaa_aaaa);
      queue_op(OP_GET, 31'd0, '0);
      for (int i = 0; i < 9; i++) queue_op(OP_PUT, 31'(7 + 100 * i), 31'(i + 1));
      queue_op(OP_GET, 31'd807, '0);
      queue_op(OP_REMOVE, 31'd107, '0);
      queue_op(OP_REMOVE, 31'd107, '0);
      queue_op(OP_PUT, 31'd807, 31'h5555_5555);
      queue_op(OP_GET, 31'd807, '0);
      queue_op(OP_NOP, '1, '1);
      queue_op(OP_REMOVE, '1, '0);
      queue_op(OP_GET, '1, '0);
      drain();

      // long receiver stall while requests keep coming
      send_gap_enable = 1'b0;
      hold_off_cycles = 600;
      random_phase(40, 300);
      drain();
      send_gap_enable = 1'b1;

      set_buckets(8'd0);
      random_phase(60, 40);
      drain();
      set_buckets(8'd1);
      random_phase(40, 30);
      drain();
      set_buckets(8'd255);
      random_phase(110, 1000);
      drain();
      set_buckets(8'd128);
      random_phase(110, 2000);
      drain();
      set_buckets(8'd3);
      random_phase(60, 60);
      drain();
      set_buckets(8'($urandom_range(2, 127)));
      random_phase(110, 500);
      drain();

      $display("covered %0d responses: %0d hits, %0d refused puts", rsp_count, hit_count,
               full_count);
      $display("bucket counts 0, 1, 3, 128, 255 and one random, with a long output stall");
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
